// ===== src/anchor_box_detection_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// anchor_box_detection_decoder_core_defines
// Assertion macros for the decoder back end.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst_n in scope.
`ifndef ANCHOR_BOX_DETECTION_DECODER_CORE_DEFINES_SVH
`define ANCHOR_BOX_DETECTION_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ABDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ABDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/abdd_pkg.sv =====
// ----------------------------------------------------------------------------
// abdd_pkg
// Shared types and constants of the anchor box detection decoder.
// ----------------------------------------------------------------------------
package abdd_pkg;

  localparam int CLASS_LIMIT_DEF    = 255;
  localparam int LOGIT_BITS_DEF     = 16;
  localparam int SIG_TABLE_BITS_DEF = 10;
  localparam int QUEUE_DEPTH_DEF    = 2;

  // Configuration register indexes
  localparam logic [2:0] REG_BOX_THR   = 3'd0;
  localparam logic [2:0] REG_CLASS_THR = 3'd1;
  localparam logic [2:0] REG_RATIO_W   = 3'd2;
  localparam logic [2:0] REG_RATIO_H   = 3'd3;
  localparam logic [2:0] REG_NUM_CLASS = 3'd4;

  // Slots of the per-row logit set
  localparam logic [2:0] SLOT_TX  = 3'd0;
  localparam logic [2:0] SLOT_TY  = 3'd1;
  localparam logic [2:0] SLOT_TW  = 3'd2;
  localparam logic [2:0] SLOT_TH  = 3'd3;
  localparam logic [2:0] SLOT_OBJ = 3'd4;
  localparam logic [2:0] SLOT_CLS = 3'd5;
  localparam int         NUM_SLOTS = 6;

  // Runtime settings seen by the decode back end
  typedef struct packed {
    logic [15:0] box_thr;
    logic [15:0] class_thr;
    logic [15:0] ratio_w;
    logic [15:0] ratio_h;
  } cfg_t;

  // One finished cell row waiting for decode
  typedef struct packed {
    logic [NUM_SLOTS-1:0][15:0] logits;
    logic [7:0]                 best_class;
    logic [7:0]                 grid_col;
    logic [7:0]                 grid_row;
    logic [2:0]                 stride_shift;
    logic [9:0]                 anc_w;
    logic [9:0]                 anc_h;
  } job_t;

endpackage

// ===== src/abdd_front.sv =====
// ----------------------------------------------------------------------------
// abdd_front
// Element intake: keeps the box and objectness logits of the current row,
// tracks the best class logit, queues each complete row with a class logit.
// ----------------------------------------------------------------------------
module abdd_front #(
  parameter int CLASS_LIMIT = abdd_pkg::CLASS_LIMIT_DEF,
  parameter int LOGIT_BITS  = abdd_pkg::LOGIT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_logit_value,
  input  logic [7:0]         in_grid_col,
  input  logic [7:0]         in_grid_row,
  input  logic [2:0]         in_stride_shift,
  input  logic [9:0]         in_anchor_w,
  input  logic [9:0]         in_anchor_h,
  input  logic               in_last,
  input  logic [7:0]         num_classes,
  input  logic               q_ready,
  output logic               q_push,
  output abdd_pkg::job_t     q_data
);

  localparam int EFF = (LOGIT_BITS < 16) ? LOGIT_BITS : 16;
  localparam int SH  = 16 - EFF;
  localparam logic signed [15:0] LOGIT_MIN = -16'sd1 <<< (EFF - 1);

  logic [7:0]             elem_r;
  logic [4:0][15:0]       box_r;
  logic signed [15:0]     best_r;
  logic [7:0]             bcls_r;

  logic signed [15:0]     v_sh;
  logic signed [15:0]     v;
  logic [7:0]             c;
  logic                   accept;
  logic                   class_ok;
  logic                   take;
  logic                   have;
  logic signed [15:0]     best_upd;
  logic [7:0]             bcls_upd;

  // Cut the logit to the configured width and sign extend
  always_comb begin
    v_sh = in_logit_value <<< SH;
    v    = v_sh >>> SH;
  end

  // Classify the element and update the running arg-max
  always_comb begin
    accept   = in_valid && in_ready;
    c        = elem_r - 8'd5;
    class_ok = (elem_r >= 8'd5) && ({1'b0, c} < {1'b0, num_classes}) &&
               ({1'b0, c} < 9'(CLASS_LIMIT));
    take     = class_ok && ((c == 8'd0) || (v > best_r));
    best_upd = take ? v : best_r;
    bcls_upd = take ? c : bcls_r;
    have     = (elem_r >= 8'd5) && (num_classes != 8'd0);
  end

  assign in_ready = q_ready;
  assign q_push   = accept && in_last && have;

  // Assemble the row for the back end
  always_comb begin
    q_data.logits[4:0]  = box_r;
    q_data.logits[5]    = best_upd;
    q_data.best_class   = bcls_upd;
    q_data.grid_col     = in_grid_col;
    q_data.grid_row     = in_grid_row;
    q_data.stride_shift = in_stride_shift;
    q_data.anc_w        = in_anchor_w;
    q_data.anc_h        = in_anchor_h;
  end

  // Hold the box and objectness logits
  always_ff @(posedge clk) begin
    if (accept && (elem_r < 8'd5)) begin
      box_r[elem_r[2:0]] <= v;
    end
  end

  // Advance the element counter, restart on the last element
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_r <= 8'd0;
      best_r <= LOGIT_MIN;
      bcls_r <= 8'd0;
    end else if (accept) begin
      if (in_last) begin
        elem_r <= 8'd0;
        best_r <= LOGIT_MIN;
        bcls_r <= 8'd0;
      end else begin
        if (elem_r != 8'hFF) begin
          elem_r <= elem_r + 8'd1;
        end
        best_r <= best_upd;
        bcls_r <= bcls_upd;
      end
    end
  end

endmodule

// ===== src/abdd_queue.sv =====
// ----------------------------------------------------------------------------
// abdd_queue
// Small FIFO of finished rows between intake and decode.
// ----------------------------------------------------------------------------
module abdd_queue #(
  parameter int DEPTH = abdd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  abdd_pkg::job_t push_data,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output abdd_pkg::job_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  abdd_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0]  wr_r;
  logic [PW-1:0]  rd_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== src/abdd_back.sv =====
// ----------------------------------------------------------------------------
// abdd_back
// Row decoder: sigmoid lookups through one table port, threshold check,
// then a short multiply sequence that forms the box and the confidence.
// ----------------------------------------------------------------------------
`include "anchor_box_detection_decoder_core_defines.svh"

module abdd_back #(
  parameter int SIG_TABLE_BITS = abdd_pkg::SIG_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  abdd_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  abdd_pkg::job_t     q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_class_id,
  output logic [15:0]        out_confidence,
  output logic signed [15:0] out_box_left,
  output logic signed [15:0] out_box_top,
  output logic [15:0]        out_box_width,
  output logic [15:0]        out_box_height
);

  localparam int TB    = SIG_TABLE_BITS;
  localparam int SIG_N = 1 << TB;

  typedef logic [16:0] rom_t [SIG_N];

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_LOOK = 10'b00_0000_0010,
    ST_CHK  = 10'b00_0000_0100,
    ST_M1   = 10'b00_0000_1000,
    ST_M2   = 10'b00_0001_0000,
    ST_M3   = 10'b00_0010_0000,
    ST_M4   = 10'b00_0100_0000,
    ST_M5   = 10'b00_1000_0000,
    ST_M6   = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } st_t;

  // Unsigned quotient by shift and subtract, used while building the table
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= dvs) begin
        rem    = rem - dvs;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid table: 1/(1+e^-x) over 0..8, Q0.16, exponent built by series
  function automatic rom_t build_rom();
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] den;
    rom_t        t;
    h    = 64'd1 << (35 - TB);
    term = 64'd1 << 32;
    r    = term;
    e    = term;
    for (int n = 1; n < 20; n++) begin
      term = div_u64((term * h) >> 32, 64'(n));
      if (n[0]) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int k = 0; k < SIG_N; k++) begin
      den  = (64'd1 << 32) + e;
      t[k] = 17'(div_u64((64'd1 << 48) + (den >> 1), den));
      e    = (e * r) >> 32;
    end
    return t;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  // Table index: |v| rounded to the nearest step, clamped to the last entry
  function automatic logic [TB-1:0] sig_index(input logic [15:0] v);
    logic [16:0]    a;
    logic [17+TB:0] s;
    a = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
    s = (((18 + TB)'(a) << TB) + (18 + TB)'(1024)) >> 11;
    if (s > (18 + TB)'(SIG_N - 1)) begin
      return '1;
    end
    return s[TB-1:0];
  endfunction

  // Truncate a Q32 value toward zero to whole units
  function automatic logic signed [20:0] trunc_q32(input logic signed [51:0] d);
    logic [51:0] mag;
    logic [20:0] q;
    mag = d[51] ? 52'(-d) : 52'(d);
    q   = {1'b0, mag[51:32]};
    return d[51] ? -$signed(q) : $signed(q);
  endfunction

  // Truncate a Q8 value toward zero and saturate to 16 signed bits
  function automatic logic [15:0] edge_sat(input logic signed [38:0] p);
    logic [38:0] mag;
    logic [30:0] q;
    mag = p[38] ? 39'(-p) : 39'(p);
    q   = mag[38:8];
    if (!p[38]) begin
      return (q > 31'd32767) ? 16'h7FFF : q[15:0];
    end
    return (q > 31'd32768) ? 16'h8000 : 16'(31'd0 - q);
  endfunction

  st_t                 state_r;
  logic [2:0]          step_r;
  abdd_pkg::job_t      job_r;
  logic [16:0]         rom_q_r;
  logic                neg_r;
  logic [15:0]         sig_r [abdd_pkg::NUM_SLOTS];
  logic [31:0]         sqw_r, sqh_r;
  logic [25:0]         arw_r, arh_r;
  logic [15:0]         conf_r;
  logic signed [33:0]  cx_r, cy_r;
  logic [41:0]         hw_r, hh_r;
  logic [57:0]         pw_r, ph_r;
  logic signed [51:0]  dx_r, dy_r;
  logic [15:0]         wid_r, hgt_r;
  logic signed [20:0]  tx_r, ty_r;
  logic signed [38:0]  px_r, py_r;
  logic                out_valid_r;
  logic [7:0]          cls_out_r;
  logic [15:0]         conf_out_r;
  logic [15:0]         left_out_r, top_out_r, wid_out_r, hgt_out_r;

  logic [2:0]          look_sel;
  logic [15:0]         sig_conv;
  logic                pass;
  logic [33:0]         cxb, cyb;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign look_sel = (step_r < 3'd6) ? step_r : abdd_pkg::SLOT_CLS;
  assign pass     = (sig_r[abdd_pkg::SLOT_OBJ] >= cfg.box_thr) &&
                    (sig_r[abdd_pkg::SLOT_CLS] >= cfg.class_thr);

  // Turn the table entry into a probability for either sign
  always_comb begin
    if (neg_r) begin
      sig_conv = 16'(17'd65536 - rom_q_r);
    end else begin
      sig_conv = rom_q_r[16] ? 16'hFFFF : rom_q_r[15:0];
    end
  end

  // Box center in Q16 before the stride shift
  always_comb begin
    cxb = (34'(sig_r[abdd_pkg::SLOT_TX]) << 1) - 34'd32768 + (34'(job_r.grid_col) << 16);
    cyb = (34'(sig_r[abdd_pkg::SLOT_TY]) << 1) - 34'd32768 + (34'(job_r.grid_row) << 16);
  end

  // Read the sigmoid table
  always_ff @(posedge clk) begin
    rom_q_r <= SIG_ROM[sig_index(job_r.logits[look_sel])];
    neg_r   <= job_r.logits[look_sel][15];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_data;
    end
    if ((state_r == ST_LOOK) && (step_r != 3'd0)) begin
      sig_r[step_r - 3'd1] <= sig_conv;
    end
    if (state_r == ST_M1) begin
      sqw_r  <= 32'(sig_r[abdd_pkg::SLOT_TW]) * 32'(sig_r[abdd_pkg::SLOT_TW]);
      sqh_r  <= 32'(sig_r[abdd_pkg::SLOT_TH]) * 32'(sig_r[abdd_pkg::SLOT_TH]);
      arw_r  <= 26'(job_r.anc_w) * 26'(cfg.ratio_w);
      arh_r  <= 26'(job_r.anc_h) * 26'(cfg.ratio_h);
      conf_r <= 16'((32'(sig_r[abdd_pkg::SLOT_CLS]) * 32'(sig_r[abdd_pkg::SLOT_OBJ])) >> 16);
      cx_r   <= $signed(cxb) <<< job_r.stride_shift;
      cy_r   <= $signed(cyb) <<< job_r.stride_shift;
    end
    if (state_r == ST_M2) begin
      hw_r <= 42'(sqw_r) * 42'(job_r.anc_w);
      hh_r <= 42'(sqh_r) * 42'(job_r.anc_h);
      pw_r <= 58'(sqw_r) * 58'(arw_r);
      ph_r <= 58'(sqh_r) * 58'(arh_r);
    end
    if (state_r == ST_M3) begin
      dx_r  <= (52'(cx_r) <<< 16) - $signed({9'd0, hw_r, 1'b0});
      dy_r  <= (52'(cy_r) <<< 16) - $signed({9'd0, hh_r, 1'b0});
      wid_r <= (|pw_r[57:54]) ? 16'hFFFF : pw_r[53:38];
      hgt_r <= (|ph_r[57:54]) ? 16'hFFFF : ph_r[53:38];
    end
    if (state_r == ST_M4) begin
      tx_r <= trunc_q32(dx_r);
      ty_r <= trunc_q32(dy_r);
    end
    if (state_r == ST_M5) begin
      px_r <= 39'(tx_r) * 39'($signed({1'b0, cfg.ratio_w})) + 39'sd128;
      py_r <= 39'(ty_r) * 39'($signed({1'b0, cfg.ratio_h})) + 39'sd128;
    end
    if (state_r == ST_M6) begin
      cls_out_r  <= job_r.best_class;
      conf_out_r <= conf_r;
      left_out_r <= edge_sat(px_r);
      top_out_r  <= edge_sat(py_r);
      wid_out_r  <= wid_r;
      hgt_out_r  <= hgt_r;
    end
  end

  // Sequence the row decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          step_r <= 3'd0;
          if (q_valid) begin
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (step_r == 3'd6) begin
            state_r <= ST_CHK;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        ST_CHK:  state_r <= pass ? ST_M1 : ST_IDLE;
        ST_M1:   state_r <= ST_M2;
        ST_M2:   state_r <= ST_M3;
        ST_M3:   state_r <= ST_M4;
        ST_M4:   state_r <= ST_M5;
        ST_M5:   state_r <= ST_M6;
        ST_M6: begin
          state_r     <= ST_OUT;
          out_valid_r <= 1'b1;
        end
        ST_OUT: begin
          if (out_ready) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b0;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_class_id   = cls_out_r;
  assign out_confidence = conf_out_r;
  assign out_box_left   = left_out_r;
  assign out_box_top    = top_out_r;
  assign out_box_width  = wid_out_r;
  assign out_box_height = hgt_out_r;

  `ABDD_ASSERT_NOW(a_look_step, state_r == ST_LOOK, step_r <= 3'd6, "table step overran")
  `ABDD_ASSERT_NEXT(a_drop_row, (state_r == ST_CHK) && !pass, state_r == ST_IDLE, "dropped row not released")
  `ABDD_ASSERT_NEXT(a_out_once, out_valid_r && out_ready, !out_valid_r, "detection repeated")
  `ABDD_ASSERT_NOW(a_valid_out, out_valid_r, state_r == ST_OUT, "valid outside output state")

endmodule

// ===== src/anchor_box_detection_decoder_core.sv =====
// ----------------------------------------------------------------------------
// anchor_box_detection_decoder_core
// Streams one cell row of logits per detection candidate and emits at most
// one decoded box per row.
// ----------------------------------------------------------------------------
// Elements are taken at one per cycle as long as the row queue has room.
// Each row that holds a class score is queued and decoded by a sequencer
// that makes six sigmoid lookups through one table port, checks the two
// thresholds, and then runs six multiply and round steps; a rejected row
// goes back to idle after the check, an accepted one after its result
// is taken at the output. The sequencer takes a new row only when idle, so
// rows stream in until the row queue (QUEUE_DEPTH rows) fills, then intake
// stalls. Configuration writes take effect at once and are meant for idle.
// ----------------------------------------------------------------------------
module anchor_box_detection_decoder_core #(
  parameter int CLASS_LIMIT    = abdd_pkg::CLASS_LIMIT_DEF,
  parameter int LOGIT_BITS     = abdd_pkg::LOGIT_BITS_DEF,
  parameter int SIG_TABLE_BITS = abdd_pkg::SIG_TABLE_BITS_DEF,
  parameter int QUEUE_DEPTH    = abdd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_logit_value,
  input  logic [7:0]         in_grid_col,
  input  logic [7:0]         in_grid_row,
  input  logic [2:0]         in_stride_shift,
  input  logic [9:0]         in_anchor_w,
  input  logic [9:0]         in_anchor_h,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_class_id,
  output logic [15:0]        out_confidence,
  output logic signed [15:0] out_box_left,
  output logic signed [15:0] out_box_top,
  output logic [15:0]        out_box_width,
  output logic [15:0]        out_box_height
);

  abdd_pkg::cfg_t cfg_r;
  logic [7:0]     num_class_r;
  logic           push;
  logic           push_ready;
  abdd_pkg::job_t push_data;
  logic           pop;
  logic           pop_valid;
  abdd_pkg::job_t pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box_thr   <= 16'd16384;
      cfg_r.class_thr <= 16'd16384;
      cfg_r.ratio_w   <= 16'd256;
      cfg_r.ratio_h   <= 16'd256;
      num_class_r     <= 8'd80;
    end else if (cfg_we) begin
      case (cfg_index)
        abdd_pkg::REG_BOX_THR:   cfg_r.box_thr   <= cfg_data;
        abdd_pkg::REG_CLASS_THR: cfg_r.class_thr <= cfg_data;
        abdd_pkg::REG_RATIO_W:   cfg_r.ratio_w   <= cfg_data;
        abdd_pkg::REG_RATIO_H:   cfg_r.ratio_h   <= cfg_data;
        abdd_pkg::REG_NUM_CLASS: num_class_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  abdd_front #(
    .CLASS_LIMIT (CLASS_LIMIT),
    .LOGIT_BITS  (LOGIT_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_logit_value  (in_logit_value),
    .in_grid_col     (in_grid_col),
    .in_grid_row     (in_grid_row),
    .in_stride_shift (in_stride_shift),
    .in_anchor_w     (in_anchor_w),
    .in_anchor_h     (in_anchor_h),
    .in_last         (in_last),
    .num_classes     (num_class_r),
    .q_ready         (push_ready),
    .q_push          (push),
    .q_data          (push_data)
  );

  abdd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  abdd_back #(
    .SIG_TABLE_BITS (SIG_TABLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (pop_valid),
    .q_data         (pop_data),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_class_id   (out_class_id),
    .out_confidence (out_confidence),
    .out_box_left   (out_box_left),
    .out_box_top    (out_box_top),
    .out_box_width  (out_box_width),
    .out_box_height (out_box_height)
  );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the anchor box detection decoder core. Streams cell
// rows of logits, predicts every detection with a bit-true model of the
// sigmoid table and the box arithmetic, and compares each result field by
// field. Runs a directed table first, then random rows over several settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 60;
  localparam int TBL_SIZE    = 1 << abdd_pkg::SIG_TABLE_BITS_DEF;

  typedef struct packed {
    logic signed [15:0] logit;
    logic [7:0]         col;
    logic [7:0]         row;
    logic [2:0]         shift;
    logic [9:0]         aw;
    logic [9:0]         ah;
    logic               last;
  } elem_t;

  typedef struct packed {
    logic [7:0]         class_id;
    logic [15:0]        confidence;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [15:0]        width;
    logic [15:0]        height;
  } det_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_logit_value;
  logic [7:0]         in_grid_col;
  logic [7:0]         in_grid_row;
  logic [2:0]         in_stride_shift;
  logic [9:0]         in_anchor_w;
  logic [9:0]         in_anchor_h;
  logic               in_last;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         out_class_id;
  logic [15:0]        out_confidence;
  logic signed [15:0] out_box_left;
  logic signed [15:0] out_box_top;
  logic [15:0]        out_box_width;
  logic [15:0]        out_box_height;

  anchor_box_detection_decoder_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_logit_value(in_logit_value), .in_grid_col(in_grid_col),
    .in_grid_row(in_grid_row), .in_stride_shift(in_stride_shift),
    .in_anchor_w(in_anchor_w), .in_anchor_h(in_anchor_h), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_class_id(out_class_id), .out_confidence(out_confidence),
    .out_box_left(out_box_left), .out_box_top(out_box_top),
    .out_box_width(out_box_width), .out_box_height(out_box_height)
  );

  // Predictor state
  longint unsigned sig_lut [TBL_SIZE];
  int unsigned     thr_box, thr_cls, scale_w, scale_h, class_count;
  int unsigned     row_pos;
  int unsigned     box_prob [4];
  int unsigned     obj_prob;
  longint          top_logit;
  int unsigned     top_class;

  det_t  pending_dets [$];
  int    err_cnt = 0;
  int    cycle_cnt = 0;
  int    burst_left;

  // Directed rows: zero row, extreme row with a class tie, short rows
  elem_t dir_tab [0:22] = '{
    '{16'sd0, 8'd0, 8'd0, 3'd0, 10'd1, 10'd1, 1'b0},
    '{16'sd0, 8'd0, 8'd0, 3'd0, 10'd1, 10'd1, 1'b0},
    '{16'sd0, 8'd0, 8'd0, 3'd0, 10'd1, 10'd1, 1'b0},
    '{16'sd0, 8'd0, 8'd0, 3'd0, 10'd1, 10'd1, 1'b0},
    '{16'sd0, 8'd0, 8'd0, 3'd0, 10'd1, 10'd1, 1'b0},
    '{16'sd0, 8'd0, 8'd0, 3'd0, 10'd1, 10'd1, 1'b0},
    '{16'sd0, 8'd0, 8'd0, 3'd0, 10'd1, 10'd1, 1'b1},
    '{16'sh7fff, 8'd255, 8'd255, 3'd7, 10'd1023, 10'd1023, 1'b0},
    '{-16'sh8000, 8'd255, 8'd255, 3'd7, 10'd1023, 10'd1023, 1'b0},
    '{16'sh7fff, 8'd255, 8'd255, 3'd7, 10'd1023, 10'd1023, 1'b0},
    '{16'sh7fff, 8'd255, 8'd255, 3'd7, 10'd1023, 10'd1023, 1'b0},
    '{16'sh7fff, 8'd255, 8'd255, 3'd7, 10'd1023, 10'd1023, 1'b0},
    '{-16'sh8000, 8'd255, 8'd255, 3'd7, 10'd1023, 10'd1023, 1'b0},
    '{-16'sh8000, 8'd255, 8'd255, 3'd7, 10'd1023, 10'd1023, 1'b1},
    '{16'sd100, 8'd3, 8'd4, 3'd3, 10'd0, 10'd0, 1'b0},
    '{16'sd100, 8'd3, 8'd4, 3'd3, 10'd0, 10'd0, 1'b0},
    '{16'sd100, 8'd3, 8'd4, 3'd3, 10'd0, 10'd0, 1'b0},
    '{16'sd100, 8'd3, 8'd4, 3'd3, 10'd0, 10'd0, 1'b1},
    '{-16'sd300, 8'd9, 8'd1, 3'd5, 10'd64, 10'd32, 1'b0},
    '{-16'sd300, 8'd9, 8'd1, 3'd5, 10'd64, 10'd32, 1'b0},
    '{16'sd300, 8'd9, 8'd1, 3'd5, 10'd64, 10'd32, 1'b0},
    '{16'sd300, 8'd9, 8'd1, 3'd5, 10'd64, 10'd32, 1'b0},
    '{16'sd900, 8'd9, 8'd1, 3'd5, 10'd64, 10'd32, 1'b1}
  };

  // Random phases: box thr, class thr, ratio w, ratio h, classes, items
  int unsigned phase_tab [0:7][0:5] = '{
    '{16384, 16384, 256, 256, 80, 170},
    '{0, 0, 65535, 65535, 1, 250},
    '{65535, 65535, 0, 0, 4, 120},
    '{8192, 4096, 384, 200, 3, 200},
    '{30000, 20000, 1000, 70, 7, 200},
    '{0, 0, 512, 512, 255, 260},
    '{20000, 0, 128, 65535, 2, 300},
    '{1, 1, 256, 256, 1, 200}
  };

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Build the Q0.16 sigmoid table with a Q32 exponential
  initial begin
    longint unsigned stp, term, ratio, ex, den;
    stp = 64'd1 << (35 - abdd_pkg::SIG_TABLE_BITS_DEF);
    term = 64'd1 << 32;
    ratio = term;
    ex = term;
    for (int n = 1; n < 20; n++) begin
      term = ((term * stp) >> 32) / n;
      if (n % 2) ratio = ratio - term;
      else ratio = ratio + term;
    end
    for (int k = 0; k < TBL_SIZE; k++) begin
      den = (64'd1 << 32) + ex;
      sig_lut[k] = ((64'd1 << 48) + den / 2) / den;
      ex = (ex * ratio) >> 32;
    end
  end

  function automatic int unsigned sigmoid_q16(longint v);
    longint unsigned mag, idx, raw;
    mag = (v < 0) ? -v : v;
    idx = ((mag << abdd_pkg::SIG_TABLE_BITS_DEF) + 1024) >> 11;
    if (idx > TBL_SIZE - 1) idx = TBL_SIZE - 1;
    raw = sig_lut[idx];
    if (v >= 0) return (raw > 65535) ? 32'd65535 : 32'(raw);
    return 32'(65536 - raw);
  endfunction

  function automatic longint shr_toward_zero(longint v, int k);
    if (v < 0) return -((-v) >> k);
    return v >> k;
  endfunction

  // Edge = trunc(trunc(center - size/2) * ratio + 1/2), saturated
  function automatic logic [15:0] edge_px(int unsigned s, int unsigned grid_pos,
                                          int unsigned shift,
                                          longint unsigned size_q32,
                                          int unsigned ratio);
    longint ctr, d, t, p;
    ctr = (longint'(s) * 2 - 32768 + longint'(grid_pos) * 65536) * (longint'(1) << shift);
    d = ctr * 65536 - longint'(size_q32 / 2);
    t = shr_toward_zero(d, 32);
    p = shr_toward_zero(t * longint'(ratio) + 128, 8);
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p[15:0];
  endfunction

  function automatic logic [15:0] size_px(longint unsigned size_q32, int unsigned ratio);
    longint unsigned v;
    v = (size_q32 * ratio) >> 40;
    return (v > 65535) ? 16'hffff : v[15:0];
  endfunction

  // Advance the predictor by one accepted item
  task automatic predict_elem(elem_t e);
    longint          v;
    int unsigned     cls_p, c;
    longint unsigned wq, hq, sw, sh;
    det_t            d;
    v = e.logit;
    if (row_pos < 4) begin
      box_prob[row_pos] = sigmoid_q16(v);
    end else if (row_pos == 4) begin
      obj_prob = sigmoid_q16(v);
    end else begin
      c = row_pos - 5;
      if (c < class_count && c < abdd_pkg::CLASS_LIMIT_DEF && (c == 0 || v > top_logit)) begin
        top_logit = v;
        top_class = c;
      end
    end
    if (e.last) begin
      if (row_pos >= 5 && class_count > 0) begin
        cls_p = sigmoid_q16(top_logit);
        if (obj_prob >= thr_box && cls_p >= thr_cls) begin
          sw = box_prob[2];
          sh = box_prob[3];
          wq = 4 * sw * sw * e.aw;
          hq = 4 * sh * sh * e.ah;
          d.class_id   = top_class[7:0];
          d.confidence = 16'((longint'(cls_p) * obj_prob) >> 16);
          d.left       = edge_px(box_prob[0], e.col, e.shift, wq, scale_w);
          d.top        = edge_px(box_prob[1], e.row, e.shift, hq, scale_h);
          d.width      = size_px(wq, scale_w);
          d.height     = size_px(hq, scale_h);
          pending_dets.insert(pending_dets.size(), d);
        end
      end
      row_pos = 0;
      top_logit = -32768;
      top_class = 0;
    end else if (row_pos < 255) begin
      row_pos++;
    end
  endtask

  // Drive one item, keeping valid high inside a burst
  task automatic send_elem(elem_t e);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid        <= 1'b1;
    in_logit_value  <= e.logit;
    in_grid_col     <= e.col;
    in_grid_row     <= e.row;
    in_stride_shift <= e.shift;
    in_anchor_w     <= e.aw;
    in_anchor_h     <= e.ah;
    in_last         <= e.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_elem(e);
    burst_left--;
  endtask

  // Hold intake until every expected detection has arrived, then settle
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_dets.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write one register; the caller drops the write enable after the last one
  task automatic write_reg(logic [2:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    @(posedge clk);
    case (idx)
      abdd_pkg::REG_BOX_THR:   thr_box     = val & 16'hffff;
      abdd_pkg::REG_CLASS_THR: thr_cls     = val & 16'hffff;
      abdd_pkg::REG_RATIO_W:   scale_w     = val & 16'hffff;
      abdd_pkg::REG_RATIO_H:   scale_h     = val & 16'hffff;
      abdd_pkg::REG_NUM_CLASS: class_count = val & 8'hff;
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] pick_logit(int bias);
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 4096) - 2048 + bias);
    endcase
  endfunction

  // Send one random row: mostly well formed, some short, long or broken
  task automatic send_row(int unsigned ncls, output int unsigned cnt);
    elem_t       e;
    int unsigned len;
    int unsigned kind;
    kind = $urandom_range(0, 19);
    if (kind < 16) len = 5 + ncls;
    else if (kind < 18) len = $urandom_range(1, 6);
    else len = 5 + ncls + $urandom_range(1, 6);
    e.col   = 8'($urandom_range(0, 255));
    e.row   = 8'($urandom_range(0, 255));
    e.shift = 3'($urandom_range(0, 7));
    e.aw    = ($urandom_range(0, 7) == 0) ? 10'd1023 : 10'($urandom_range(0, 200));
    e.ah    = ($urandom_range(0, 7) == 0) ? 10'd1023 : 10'($urandom_range(0, 200));
    for (int i = 0; i < len; i++) begin
      e.logit = pick_logit(i == 4 ? 1536 : 0);
      e.last  = (i == len - 1);
      if ($urandom_range(0, 15) == 0) begin
        e.col = 8'($urandom_range(0, 255));
        e.row = 8'($urandom_range(0, 255));
      end
      send_elem(e);
    end
    cnt = len;
  endtask

  // Stimulus and end of run
  initial begin
    int unsigned sent, got;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= abdd_pkg::REG_BOX_THR;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    in_logit_value  <= '0;
    in_grid_col     <= '0;
    in_grid_row     <= '0;
    in_stride_shift <= '0;
    in_anchor_w     <= '0;
    in_anchor_h     <= '0;
    in_last         <= 1'b0;
    burst_left = 0;
    thr_box = 16384; thr_cls = 16384; scale_w = 256; scale_h = 256; class_count = 80;
    row_pos = 0; obj_prob = 0; top_logit = -32768; top_class = 0;
    for (int i = 0; i < 4; i++) box_prob[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    write_reg(abdd_pkg::REG_BOX_THR, 0);
    write_reg(abdd_pkg::REG_CLASS_THR, 0);
    write_reg(abdd_pkg::REG_NUM_CLASS, 2);
    cfg_we <= 1'b0;
    foreach (dir_tab[i]) send_elem(dir_tab[i]);
    drain();

    // Random phases
    for (int p = 0; p < 8; p++) begin
      write_reg(abdd_pkg::REG_BOX_THR, phase_tab[p][0]);
      write_reg(abdd_pkg::REG_CLASS_THR, phase_tab[p][1]);
      write_reg(abdd_pkg::REG_RATIO_W, phase_tab[p][2]);
      write_reg(abdd_pkg::REG_RATIO_H, phase_tab[p][3]);
      write_reg(abdd_pkg::REG_NUM_CLASS, phase_tab[p][4]);
      cfg_we <= 1'b0;
      sent = 0;
      while (sent < phase_tab[p][5]) begin
        send_row(phase_tab[p][4], got);
        sent += got;
        // Pause intake until the output side has caught up
        if (p == 6 && sent > 150 && sent < 160) drain();
      end
      drain();
    end

    if (err_cnt == 0 && pending_dets.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Receiver stall pattern: free-running stretches and random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (cycle_cnt[8:7] == 2'd0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each accepted detection with the oldest prediction
  always @(posedge clk) begin
    det_t exp_d, got_d;
    if (rst_n && out_valid && out_ready) begin
      got_d = '{out_class_id, out_confidence, out_box_left, out_box_top,
                out_box_width, out_box_height};
      if (pending_dets.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected detection %p", got_d);
      end else begin
        exp_d = pending_dets.pop_front();
        if (exp_d != got_d) begin
          err_cnt++;
          if (err_cnt <= 10) $display("mismatch: expected %p actual %p", exp_d, got_d);
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
